[hw/rtl/lhc_pkg.sv]
// Shared types, codes and the key mask helper function of the keyed LRU cache engine.
`default_nettype none

package lhc_pkg;

    // Table sizes; the result fields are sized for these, and BUCKETS is a power of two.
    localparam int MAX_SLOTS = 64;
    localparam int BUCKETS   = 128;
    localparam int KEY_BYTES = 8;

    // Operation codes of a request.
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [3:0] RS_HIT       = 4'd0;
    localparam logic [3:0] RS_MISS      = 4'd1;
    localparam logic [3:0] RS_STALE     = 4'd2;
    localparam logic [3:0] RS_ADDED     = 4'd3;
    localparam logic [3:0] RS_REPLACED  = 4'd4;
    localparam logic [3:0] RS_FULL      = 4'd5;
    localparam logic [3:0] RS_TOO_LONG  = 4'd6;
    localparam logic [3:0] RS_REMOVED   = 4'd7;
    localparam logic [3:0] RS_NOT_FOUND = 4'd8;
    localparam logic [3:0] RS_CLEARED   = 4'd9;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVICT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_KEY = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [63:0] key_hash;
        logic [63:0] tag;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [3:0] status;
        logic [5:0] slot;
        logic       evicted;
        logic [5:0] evicted_slot;
        logic [6:0] live_count;
    } t_res;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_F_BRD, S_F_BCHK, S_F_SCHK, S_HIT, S_MISS,
        S_O_SCAN, S_O_END, S_E_BRD, S_E_BCHK, S_E_NRD, S_E_NCHK, S_E_HOME,
        S_E_HOLE, S_E_FREE, S_I_START, S_I_NF, S_I_BRD, S_I_BCHK, S_DONE
    } t_state;

    // Datapath steps issued by the controller.
    typedef enum logic [4:0] {
        C_IDLE, C_DECODE, C_F_BRD, C_F_BCHK, C_F_SCHK, C_HIT, C_MISS,
        C_O_SCAN, C_O_END, C_E_BRD, C_E_BCHK, C_E_NRD, C_E_NCHK, C_E_HOME,
        C_E_HOLE, C_E_FREE, C_I_START, C_I_NF, C_I_BRD, C_I_BCHK, C_DONE
    } t_step;

    // Command from controller to datapath.
    typedef struct packed {
        t_step step;
        logic  take;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] op;
        logic       len_ok;
        logic       bkt_end;
        logic       match;
        logic       full;
        logic       evict_en;
        logic       free_bad;
        logic       scan_done;
        logic       best_none;
        logic       e_found;
        logic       e_stop;
        logic       n_end;
        logic       i_empty;
        logic       out_free;
    } t_sts;

    // Keep the low len bytes of a key.
    function automatic logic [63:0] key_mask(input logic [63:0] key, input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[8*i +: 8] = key[8*i +: 8];
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lru_hash_cache_engine.sv]
// Flow to result: a probe reads bucket then slot for each occupied bucket in turn; clear or bad length skip it.
// A new add, after its miss, writes the free slot and then walks the occupied buckets to the free one.
// An evicting add first scans the stamps over the capacity and removes the oldest slot.
// A removal walks the buckets to its entry, then closes the gap by a backward shift and frees the slot.
// One request at a time; the next is taken in the idle state once its result is registered.
// Reset is synchronous; it empties the table, zeroes the use clock and loads defaults.
`default_nettype none

module lru_hash_cache_engine
    import lhc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_req                  i_in_req,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_res                       o_out_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    lhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tables, registers and result stage.
    lhc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

[hw/rtl/lhc_ctrl.sv]
// Controller state machine that sequences probes, scans and table updates.
`default_nettype none

module lhc_ctrl
    import lhc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.op == OP_CLEAR || !i_sts.len_ok) n_state = S_DONE;
                else n_state = S_F_BRD;
            end
            S_F_BRD: n_state = S_F_BCHK;
            S_F_BCHK: begin
                n_state = i_sts.bkt_end ? S_MISS : S_F_SCHK;
            end
            S_F_SCHK: begin
                n_state = i_sts.match ? S_HIT : S_F_BRD;
            end
            S_HIT: begin
                n_state = (i_sts.op == OP_REMOVE) ? S_E_BRD : S_DONE;
            end
            S_MISS: begin
                if (i_sts.op != OP_ADD) n_state = S_DONE;
                else if (i_sts.full) n_state = i_sts.evict_en ? S_O_SCAN : S_DONE;
                else if (i_sts.free_bad) n_state = S_DONE;
                else n_state = S_I_START;
            end
            S_O_SCAN: begin
                if (i_sts.scan_done) n_state = S_O_END;
            end
            S_O_END: begin
                n_state = i_sts.best_none ? S_DONE : S_E_BRD;
            end
            S_E_BRD: n_state = S_E_BCHK;
            S_E_BCHK: begin
                if (i_sts.e_found) n_state = S_E_NRD;
                else if (i_sts.e_stop) n_state = S_E_FREE;
                else n_state = S_E_BRD;
            end
            S_E_NRD: n_state = S_E_NCHK;
            S_E_NCHK: begin
                n_state = i_sts.n_end ? S_E_HOLE : S_E_HOME;
            end
            S_E_HOME: n_state = S_E_NRD;
            S_E_HOLE: n_state = S_E_FREE;
            S_E_FREE: begin
                n_state = (i_sts.op == OP_REMOVE) ? S_DONE : S_I_START;
            end
            S_I_START: n_state = S_I_NF;
            S_I_NF: n_state = S_I_BRD;
            S_I_BRD: n_state = S_I_BCHK;
            S_I_BCHK: begin
                n_state = i_sts.i_empty ? S_DONE : S_I_BRD;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: one datapath step per state.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_cmd.take = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_IDLE:    o_cmd.step = C_IDLE;
            S_DECODE:  o_cmd.step = C_DECODE;
            S_F_BRD:   o_cmd.step = C_F_BRD;
            S_F_BCHK:  o_cmd.step = C_F_BCHK;
            S_F_SCHK:  o_cmd.step = C_F_SCHK;
            S_HIT:     o_cmd.step = C_HIT;
            S_MISS:    o_cmd.step = C_MISS;
            S_O_SCAN:  o_cmd.step = C_O_SCAN;
            S_O_END:   o_cmd.step = C_O_END;
            S_E_BRD:   o_cmd.step = C_E_BRD;
            S_E_BCHK:  o_cmd.step = C_E_BCHK;
            S_E_NRD:   o_cmd.step = C_E_NRD;
            S_E_NCHK:  o_cmd.step = C_E_NCHK;
            S_E_HOME:  o_cmd.step = C_E_HOME;
            S_E_HOLE:  o_cmd.step = C_E_HOLE;
            S_E_FREE:  o_cmd.step = C_E_FREE;
            S_I_START: o_cmd.step = C_I_START;
            S_I_NF:    o_cmd.step = C_I_NF;
            S_I_BRD:   o_cmd.step = C_I_BRD;
            S_I_BCHK:  o_cmd.step = C_I_BCHK;
            S_DONE:    o_cmd.step = C_DONE;
            default:   o_cmd.step = C_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/lhc_dp.sv]
// Datapath: bucket and slot memories, request registers and result register.
`default_nettype none

module lhc_dp
    import lhc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire t_req                  i_req,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_res                       o_out_res
);

    localparam int SIW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW     = $clog2(MAX_SLOTS + 1);
    localparam int BW     = $clog2(BUCKETS);
    localparam int CAPMAX = (MAX_SLOTS < BUCKETS - 1) ? MAX_SLOTS : BUCKETS - 1;
    localparam logic [SW-1:0]  NONE  = SW'(MAX_SLOTS);
    localparam logic [BW:0]    NBKT  = (BW+1)'(BUCKETS);
    localparam logic [3:0]     KBMAX = 4'(KEY_BYTES);

    // Slot memories and bucket memory.
    logic [63:0]   r_hash_mem  [MAX_SLOTS];
    logic [63:0]   r_tag_mem   [MAX_SLOTS];
    logic [63:0]   r_stamp_mem [MAX_SLOTS];
    logic [3:0]    r_len_mem   [MAX_SLOTS];
    logic [SW-1:0] r_nf_mem    [MAX_SLOTS];
    logic [63:0]   r_key_mem   [MAX_SLOTS];
    logic [SW-1:0] r_bkt_mem   [BUCKETS];
    logic [MAX_SLOTS-1:0] r_sval;
    logic [BUCKETS-1:0]   r_bval;

    // Registered read ports.
    logic [63:0]    r_sq_hash, r_sq_tag, r_sq_stamp, r_sq_key;
    logic [3:0]     r_sq_len;
    logic [SW-1:0]  r_sq_nf;
    logic [SIW-1:0] r_sq_addr;
    logic           r_sq_ok;
    logic [SW-1:0]  r_bq;
    logic           r_bq_ok;

    // Configuration and global state.
    logic [6:0]  r_lim;
    logic        r_evict;
    logic [3:0]  r_lkey;
    logic [63:0] r_clock;
    logic [SW-1:0] r_live, r_free;

    // Request working registers.
    t_req           r_req;
    logic [63:0]    r_kb;
    logic [BW-1:0]  r_b, r_hole, r_next, r_bhome;
    logic [BW:0]    r_n;
    logic [SIW-1:0] r_s, r_vs, r_pi;
    logic [63:0]    r_w_hash, r_w_tag, r_w_key;
    logic [3:0]     r_w_len;
    logic [SW-1:0]  r_mv, r_i, r_best;
    logic           r_pv;
    logic [63:0]    r_bstamp;
    logic [3:0]     r_res_status;
    logic [SIW-1:0] r_res_slot, r_evs;
    logic           r_ev;
    logic           r_out_valid;
    t_res           r_out;

    // Combinational helpers.
    logic [SW-1:0]  cap, bv, w_nf, dflt_nf;
    logic [63:0]    w_hash, w_tag, w_stamp;
    logic [3:0]     w_len, klim;
    logic           len_ok, stays, tag_eq, do_clear;
    logic [BW-1:0]  w_home;
    logic           s_re, s_we, b_re, b_we;
    logic [SIW-1:0] s_raddr, s_waddr;
    logic [63:0]    s_whash, s_wtag, s_wstamp, s_wkey;
    logic [3:0]     s_wlen;
    logic [SW-1:0]  s_wnf, b_wdata;
    logic [BW-1:0]  b_raddr, b_waddr;

    // Effective capacity and key length limit.
    always_comb begin
        if (r_lim == 7'd0) cap = SW'(1);
        else if (32'(r_lim) > CAPMAX) cap = SW'(CAPMAX);
        else cap = SW'(r_lim);
        klim = (r_lkey < KBMAX) ? r_lkey : KBMAX;
        len_ok = (i_cmd.step == C_DECODE) ? (r_req.key_length != 4'd0 && r_req.key_length <= klim)
                                          : 1'b1;
    end

    // Read data with reset values for entries never written since a clear.
    always_comb begin
        bv      = r_bq_ok ? r_bq : '0;
        dflt_nf = (SW'(r_sq_addr) + SW'(1) < cap) ? SW'(r_sq_addr) + SW'(1) : NONE;
        w_hash  = r_sq_ok ? r_sq_hash  : '0;
        w_tag   = r_sq_ok ? r_sq_tag   : '0;
        w_stamp = r_sq_ok ? r_sq_stamp : '0;
        w_len   = r_sq_ok ? r_sq_len   : '0;
        w_nf    = r_sq_ok ? r_sq_nf    : dflt_nf;
        w_home  = w_hash[BW-1:0];
        tag_eq  = (r_w_tag == r_req.tag);
        stays   = (r_hole <= r_next) ? (r_hole < w_home && w_home <= r_next)
                                     : (r_hole < w_home || w_home <= r_next);
        do_clear = (i_cmd.step == C_DECODE && r_req.opcode == OP_CLEAR) ||
                   (i_cfg_we && i_cfg_idx == CFG_ENTRY_LIMIT);
    end

    // Memory read and write controls per step.
    always_comb begin
        s_re = 1'b0;  s_raddr = SIW'(bv - SW'(1));
        s_we = 1'b0;  s_waddr = r_s;
        s_whash = r_w_hash; s_wtag = r_w_tag; s_wstamp = r_clock + 64'd1;
        s_wlen = r_w_len;   s_wnf = NONE;     s_wkey = r_w_key;
        b_re = 1'b0;  b_raddr = r_b;
        b_we = 1'b0;  b_waddr = r_b;  b_wdata = '0;
        case (i_cmd.step)
            C_F_BRD, C_I_BRD: b_re = 1'b1;
            C_E_BRD: begin
                b_re = 1'b1;
                b_raddr = r_hole;
            end
            C_E_NRD: begin
                b_re = 1'b1;
                b_raddr = r_next;
            end
            C_F_BCHK, C_E_NCHK: s_re = 1'b1;
            C_O_SCAN: begin
                s_re = (r_i < cap);
                s_raddr = SIW'(r_i);
            end
            C_I_START: begin
                s_re = 1'b1;
                s_raddr = SIW'(r_free);
            end
            C_HIT: begin
                if (r_req.opcode == OP_ADD) begin
                    s_we = 1'b1;
                    s_wtag = r_req.tag;
                end else if (r_req.opcode == OP_LOOKUP && tag_eq) begin
                    s_we = 1'b1;
                end
            end
            C_E_FREE: begin
                s_we = 1'b1;  s_waddr = r_vs;
                s_whash = '0; s_wtag = '0; s_wstamp = '0; s_wlen = '0;
                s_wnf = r_free;
            end
            C_I_NF: begin
                s_we = 1'b1;
                s_whash = r_req.key_hash; s_wtag = r_req.tag;
                s_wlen = r_req.key_length; s_wkey = r_kb;
            end
            C_E_HOME: begin
                b_we = !stays;
                b_waddr = r_hole;
                b_wdata = r_mv;
            end
            C_E_HOLE: begin
                b_we = 1'b1;
                b_waddr = r_hole;
            end
            C_I_BCHK: begin
                b_we = o_sts.i_empty;
                b_wdata = SW'(r_s) + SW'(1);
            end
            default: ;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_sts.op        = r_req.opcode;
        o_sts.len_ok    = len_ok;
        o_sts.bkt_end   = (bv == '0) || (r_n == NBKT);
        o_sts.match     = (w_len == r_req.key_length) && (w_hash == r_req.key_hash) &&
                          (r_sq_key == r_kb);
        o_sts.full      = (r_live >= cap);
        o_sts.evict_en  = r_evict;
        o_sts.free_bad  = (r_free >= cap);
        o_sts.scan_done = (r_i >= cap) && !r_pv;
        o_sts.best_none = (r_best == NONE);
        o_sts.e_found   = (bv == SW'(r_vs) + SW'(1));
        o_sts.e_stop    = (bv == '0) || (r_n >= NBKT);
        o_sts.n_end     = (r_n == NBKT) || (bv == '0);
        o_sts.i_empty   = (bv == '0) || (r_n == NBKT);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // Memory arrays and their registered read data.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_hash_mem[s_waddr]  <= s_whash;
            r_tag_mem[s_waddr]   <= s_wtag;
            r_stamp_mem[s_waddr] <= s_wstamp;
            r_len_mem[s_waddr]   <= s_wlen;
            r_nf_mem[s_waddr]    <= s_wnf;
            r_key_mem[s_waddr]   <= s_wkey;
        end
        if (s_re) begin
            r_sq_hash  <= r_hash_mem[s_raddr];
            r_sq_tag   <= r_tag_mem[s_raddr];
            r_sq_stamp <= r_stamp_mem[s_raddr];
            r_sq_len   <= r_len_mem[s_raddr];
            r_sq_nf    <= r_nf_mem[s_raddr];
            r_sq_key   <= r_key_mem[s_raddr];
            r_sq_addr  <= s_raddr;
        end
        if (b_we) r_bkt_mem[b_waddr] <= b_wdata;
        if (b_re) r_bq <= r_bkt_mem[b_raddr];
    end

    // Control state: valid bits, configuration, counters, output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval <= '0;  r_bval <= '0;
            r_sq_ok <= 1'b0; r_bq_ok <= 1'b0;
            r_lim <= 7'd64; r_evict <= 1'b1; r_lkey <= 4'd8;
            r_clock <= '0; r_live <= '0; r_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_re) r_sq_ok <= r_sval[s_raddr];
            if (b_re) r_bq_ok <= r_bval[b_raddr];
            if (s_we) r_sval[s_waddr] <= 1'b1;
            if (b_we) r_bval[b_waddr] <= 1'b1;
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENTRY_LIMIT: r_lim <= i_cfg_data;
                    CFG_EVICT:       r_evict <= i_cfg_data[0];
                    CFG_LONGEST_KEY: r_lkey <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // Stamp clock, live count and free list head.
            case (i_cmd.step)
                C_HIT: begin
                    if (s_we) r_clock <= r_clock + 64'd1;
                end
                C_E_FREE: begin
                    r_free <= SW'(r_vs);
                    if (r_live != '0) r_live <= r_live - SW'(1);
                end
                C_I_NF: begin
                    r_free <= w_nf;
                    r_clock <= r_clock + 64'd1;
                end
                C_I_BCHK: begin
                    if (o_sts.i_empty) r_live <= r_live + SW'(1);
                end
                default: ;
            endcase
            if (do_clear) begin
                r_sval <= '0; r_bval <= '0;
                r_live <= '0; r_free <= '0;
            end
            // Result register toward the output channel.
            if (i_cmd.step == C_DONE && o_sts.out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_req <= i_req;
        case (i_cmd.step)
            C_DECODE: begin
                r_kb <= key_mask(r_req.key, r_req.key_length);
                r_b <= r_req.key_hash[BW-1:0];
                r_n <= '0;
                r_ev <= 1'b0; r_evs <= '0; r_res_slot <= '0;
                if (r_req.opcode == OP_CLEAR) r_res_status <= RS_CLEARED;
                else if (r_req.opcode == OP_LOOKUP) r_res_status <= RS_MISS;
                else if (r_req.opcode == OP_REMOVE) r_res_status <= RS_NOT_FOUND;
                else r_res_status <= RS_TOO_LONG;
            end
            C_F_BCHK: r_s <= SIW'(bv - SW'(1));
            C_F_SCHK: begin
                r_w_hash <= w_hash; r_w_tag <= w_tag;
                r_w_len <= w_len;   r_w_key <= r_sq_key;
                if (!o_sts.match) begin
                    r_b <= r_b + BW'(1);
                    r_n <= r_n + (BW+1)'(1);
                end
            end
            C_HIT: begin
                // A removal reports no slot.
                if (r_req.opcode != OP_REMOVE) r_res_slot <= r_s;
                if (r_req.opcode == OP_ADD) r_res_status <= RS_REPLACED;
                else if (r_req.opcode == OP_LOOKUP) r_res_status <= tag_eq ? RS_HIT : RS_STALE;
                r_vs <= r_s;
                r_hole <= r_w_hash[BW-1:0];
                r_n <= '0;
            end
            C_MISS: begin
                if (r_req.opcode == OP_ADD) r_res_status <= RS_FULL;
                r_i <= '0; r_pv <= 1'b0; r_best <= NONE;
            end
            C_O_SCAN: begin
                if (r_i < cap) begin
                    r_pi <= SIW'(r_i);
                    r_i <= r_i + SW'(1);
                    r_pv <= 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv && w_len != 4'd0 && (r_best == NONE || w_stamp < r_bstamp)) begin
                    r_best <= SW'(r_pi);
                    r_bstamp <= w_stamp;
                    r_bhome <= w_home;
                end
            end
            C_O_END: begin
                r_vs <= SIW'(r_best);
                r_hole <= r_bhome;
                r_n <= '0;
                r_ev <= !o_sts.best_none;
                r_evs <= o_sts.best_none ? '0 : SIW'(r_best);
            end
            C_E_BCHK: begin
                if (o_sts.e_found) begin
                    r_next <= r_hole + BW'(1);
                    r_n <= '0;
                end else if (!o_sts.e_stop) begin
                    r_hole <= r_hole + BW'(1);
                    r_n <= r_n + (BW+1)'(1);
                end
            end
            C_E_NCHK: r_mv <= bv;
            C_E_HOME: begin
                if (!stays) r_hole <= r_next;
                r_next <= r_next + BW'(1);
                r_n <= r_n + (BW+1)'(1);
            end
            C_E_FREE: begin
                if (r_req.opcode == OP_REMOVE) r_res_status <= RS_REMOVED;
            end
            C_I_START: r_s <= SIW'(r_free);
            C_I_NF: begin
                r_b <= r_req.key_hash[BW-1:0];
                r_n <= '0;
            end
            C_I_BCHK: begin
                if (o_sts.i_empty) begin
                    r_res_status <= RS_ADDED;
                    r_res_slot <= r_s;
                end else begin
                    r_b <= r_b + BW'(1);
                    r_n <= r_n + (BW+1)'(1);
                end
            end
            C_DONE: begin
                if (o_sts.out_free) begin
                    r_out.status <= r_res_status;
                    r_out.slot <= 6'(r_res_slot);
                    r_out.evicted <= r_ev;
                    r_out.evicted_slot <= 6'(r_evs);
                    r_out.live_count <= 7'(r_live);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of the keyed LRU hash cache engine, with scoreboard and stimulus.
`default_nettype none

import lhc_pkg::*;

// Scoreboard: keeps its own copy of the cache state and the queue of expected results.
class cache_scoreboard;
    localparam int NSLOT = 64;
    localparam int NBKT  = 128;
    localparam int NONE  = 64;

    int          bkt[NBKT];
    logic [63:0] s_hash[NSLOT];
    logic [63:0] s_tag[NSLOT];
    logic [63:0] s_stamp[NSLOT];
    logic [63:0] s_key[NSLOT];
    int          s_len[NSLOT];
    int          s_next[NSLOT];
    logic [63:0] use_ctr;
    int          live;
    int          head_free;
    int          lim_reg;
    int          evict_reg;
    int          longest_reg;

    t_res        pending_results[$];
    int          errors;
    int          status_seen[16];
    int          evictions;
    int          checked;

    function new();
        errors = 0;
        evictions = 0;
        checked = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (s_key[i]) s_key[i] = '0;
        use_ctr = '0;
        lim_reg = 64;
        evict_reg = 1;
        longest_reg = 8;
        wipe();
    endfunction

    function int capacity();
        int c;
        c = lim_reg;
        if (c < 1) c = 1;
        if (c > NSLOT) c = NSLOT;
        return c;
    endfunction

    // Empty buckets and slots, rebuild the free list over the capacity.
    function void wipe();
        int c;
        c = capacity();
        foreach (bkt[i]) bkt[i] = 0;
        for (int i = 0; i < NSLOT; i++) begin
            s_hash[i] = '0;
            s_tag[i] = '0;
            s_stamp[i] = '0;
            s_len[i] = 0;
            s_next[i] = (i + 1 < c) ? i + 1 : NONE;
        end
        live = 0;
        head_free = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENTRY_LIMIT: begin
                lim_reg = int'(data);
                wipe();
            end
            CFG_EVICT:       evict_reg = int'(data[0]);
            CFG_LONGEST_KEY: longest_reg = int'(data[3:0]);
            default: ;
        endcase
    endfunction

    function int probe(logic [63:0] kb, int len, logic [63:0] h);
        int b;
        int s;
        b = int'(h[6:0]);
        for (int n = 0; n < NBKT; n++) begin
            s = bkt[b];
            if (s == 0) return NONE;
            s = s - 1;
            if (s_len[s] == len && s_hash[s] == h && s_key[s] == kb) return s;
            b = (b + 1) % NBKT;
        end
        return NONE;
    endfunction

    // Drop a slot from the bucket table and close the gap by backward shift.
    function void unlink_bucket(int slot);
        int hole;
        int nxt;
        int s;
        int home;
        int n;
        bit stays;
        hole = int'(s_hash[slot][6:0]);
        n = 0;
        while (bkt[hole] != slot + 1) begin
            if (bkt[hole] == 0 || n >= NBKT) return;
            hole = (hole + 1) % NBKT;
            n++;
        end
        nxt = (hole + 1) % NBKT;
        for (n = 0; n < NBKT && bkt[nxt] != 0; n++) begin
            s = bkt[nxt] - 1;
            home = int'(s_hash[s][6:0]);
            stays = (hole <= nxt) ? (hole < home && home <= nxt)
                                  : (hole < home || home <= nxt);
            if (!stays) begin
                bkt[hole] = bkt[nxt];
                hole = nxt;
            end
            nxt = (nxt + 1) % NBKT;
        end
        bkt[hole] = 0;
    endfunction

    function void free_slot(int slot);
        unlink_bucket(slot);
        s_hash[slot] = '0;
        s_tag[slot] = '0;
        s_stamp[slot] = '0;
        s_len[slot] = 0;
        s_next[slot] = head_free;
        head_free = slot;
        if (live > 0) live--;
    endfunction

    function int least_recent();
        int best;
        best = NONE;
        for (int i = 0; i < capacity(); i++) begin
            if (s_len[i] == 0) continue;
            if (best == NONE || s_stamp[i] < s_stamp[best]) best = i;
        end
        return best;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(t_req r);
        t_res        e;
        int          len;
        int          klim;
        bit          len_ok;
        logic [63:0] kb;
        int          s;
        int          o;
        int          b;
        bit          ok;
        len = int'(r.key_length);
        klim = (longest_reg < 8) ? longest_reg : 8;
        len_ok = (len >= 1 && len <= klim);
        kb = '0;
        if (len_ok) kb = (len >= 8) ? r.key : (r.key & ((64'd1 << (8 * len)) - 64'd1));
        e = '0;
        case (r.opcode)
            OP_CLEAR: begin
                wipe();
                e.status = RS_CLEARED;
            end
            OP_LOOKUP: begin
                s = len_ok ? probe(kb, len, r.key_hash) : NONE;
                if (s == NONE) begin
                    e.status = RS_MISS;
                end else if (s_tag[s] != r.tag) begin
                    e.status = RS_STALE;
                    e.slot = 6'(s);
                end else begin
                    use_ctr = use_ctr + 1;
                    s_stamp[s] = use_ctr;
                    e.status = RS_HIT;
                    e.slot = 6'(s);
                end
            end
            OP_REMOVE: begin
                s = len_ok ? probe(kb, len, r.key_hash) : NONE;
                if (s == NONE) begin
                    e.status = RS_NOT_FOUND;
                end else begin
                    free_slot(s);
                    e.status = RS_REMOVED;
                end
            end
            default: begin
                if (!len_ok) begin
                    e.status = RS_TOO_LONG;
                end else begin
                    s = probe(kb, len, r.key_hash);
                    if (s != NONE) begin
                        s_tag[s] = r.tag;
                        use_ctr = use_ctr + 1;
                        s_stamp[s] = use_ctr;
                        e.status = RS_REPLACED;
                        e.slot = 6'(s);
                    end else begin
                        ok = 1;
                        if (live >= capacity()) begin
                            o = evict_reg ? least_recent() : NONE;
                            if (o == NONE) begin
                                ok = 0;
                            end else begin
                                free_slot(o);
                                e.evicted = 1'b1;
                                e.evicted_slot = 6'(o);
                            end
                        end
                        if (ok && head_free >= capacity()) ok = 0;
                        if (!ok) begin
                            e.status = RS_FULL;
                        end else begin
                            s = head_free;
                            head_free = s_next[s];
                            s_hash[s] = r.key_hash;
                            s_tag[s] = r.tag;
                            use_ctr = use_ctr + 1;
                            s_stamp[s] = use_ctr;
                            s_len[s] = len;
                            s_next[s] = NONE;
                            s_key[s] = kb;
                            b = int'(r.key_hash[6:0]);
                            for (int n = 0; n < NBKT && bkt[b] != 0; n++) b = (b + 1) % NBKT;
                            bkt[b] = s + 1;
                            live++;
                            e.status = RS_ADDED;
                            e.slot = 6'(s);
                        end
                    end
                end
            end
        endcase
        e.live_count = 7'(live);
        pending_results.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(t_res got);
        t_res e;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual %p", $time, got);
            return;
        end
        e = pending_results.pop_front();
        checked++;
        status_seen[e.status]++;
        if (e.evicted) evictions++;
        if (got.status !== e.status || got.slot !== e.slot || got.evicted !== e.evicted ||
            got.evicted_slot !== e.evicted_slot || got.live_count !== e.live_count) begin
            errors++;
            if (errors <= 30) begin
                $display("%0t: result mismatch: expected status %0d slot %0d evicted %0d/%0d live %0d",
                         $time, e.status, e.slot, e.evicted, e.evicted_slot, e.live_count);
                $display("%0t:                   actual status %0d slot %0d evicted %0d/%0d live %0d",
                         $time, got.status, got.slot, got.evicted, got.evicted_slot,
                         got.live_count);
            end
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 190;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_req                  i_in_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_res                  o_out_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cache_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int cycle_count;
    int sent;

    // Keys reused across a segment so that hits, stale tags and evictions happen.
    logic [63:0] pool_key[80];
    logic [63:0] pool_hash[80];
    logic [63:0] pool_tag[80];
    logic [3:0]  pool_len[80];
    int          pool_n;

    lru_hash_cache_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_res(o_out_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** lru_hash_cache_engine: FAILED **");
            $finish;
        end
    end

    // Result side: check accepted results and choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_res);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offer one request and wait until it is accepted; valid stays high afterwards.
    task automatic send(t_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_fields(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                               logic [63:0] h, logic [63:0] tag);
        t_req r;
        r.opcode = op;
        r.key = key;
        r.key_length = len;
        r.key_hash = h;
        r.tag = tag;
        send(r);
    endtask

    // Let every expected result come back before the registers change.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [6:0] lim, logic ev, logic [3:0] longest);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ENTRY_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        sb.write_reg(CFG_ENTRY_LIMIT, lim);
        i_cfg_idx <= CFG_EVICT;
        i_cfg_data <= 7'(ev);
        @(posedge i_clk);
        sb.write_reg(CFG_EVICT, 7'(ev));
        i_cfg_idx <= CFG_LONGEST_KEY;
        i_cfg_data <= 7'(longest);
        @(posedge i_clk);
        sb.write_reg(CFG_LONGEST_KEY, 7'(longest));
        i_cfg_we <= 1'b0;
    endtask

    // Build a key pool; half the hashes share a few home buckets to force probe runs.
    task automatic fill_pool(int n);
        logic [63:0] h;
        pool_n = n;
        for (int i = 0; i < n; i++) begin
            pool_key[i] = {$urandom, $urandom};
            pool_len[i] = 4'($urandom_range(1, 8));
            h = {$urandom, $urandom};
            case ($urandom_range(3))
                0: h[6:0] = 7'($urandom_range(0, 3));
                1: h[6:0] = 7'($urandom_range(124, 127));
                default: ;
            endcase
            if (i > 0 && $urandom_range(9) == 0) h = pool_hash[$urandom_range(0, i - 1)];
            pool_hash[i] = h;
            pool_tag[i] = ($urandom_range(1) == 0) ? 64'($urandom_range(3)) : {$urandom, $urandom};
        end
    endtask

    // One random request drawn mostly from the pool, with junk above the key length.
    task automatic send_random();
        int          i;
        int          pick;
        logic [1:0]  op;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] tag;
        i = $urandom_range(0, pool_n - 1);
        len = pool_len[i];
        key = pool_key[i];
        if (len < 8) key = key ^ ({$urandom, $urandom} << (8 * len));
        tag = ($urandom_range(9) < 7) ? pool_tag[i] : {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 40) op = OP_LOOKUP;
        else if (pick < 78) op = OP_ADD;
        else if (pick < 98) op = OP_REMOVE;
        else op = OP_CLEAR;
        if ($urandom_range(49) == 0) len = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        send_fields(op, key, len, pool_hash[i], tag);
    endtask

    initial begin
        logic [6:0] seg_limit[SEGMENTS] = '{7'd64, 7'd5, 7'd100, 7'd0, 7'd17, 7'd64};
        logic       seg_evict[SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        logic [3:0] seg_longest[SEGMENTS] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd8, 4'd6};
        int cap;
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, hit/stale/replace, bad lengths, collisions, wrap and removal.
        send_fields(OP_ADD, '1, 4'd8, '1, '1);
        send_fields(OP_LOOKUP, '1, 4'd8, '1, '1);
        send_fields(OP_LOOKUP, '1, 4'd8, '1, '0);
        send_fields(OP_ADD, '1, 4'd8, '1, 64'h5);
        send_fields(OP_ADD, 64'h0000_0000_0000_0011, 4'd1, 64'h0000_0000_0000_007F, '0);
        send_fields(OP_ADD, 64'hFFFF_FFFF_FFFF_FF22, 4'd1, 64'h0000_0000_0000_007F, '0);
        send_fields(OP_ADD, 64'h0000_0000_0000_0033, 4'd1, 64'h8000_0000_0000_007E, '0);
        send_fields(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AA11, 4'd1, 64'h0000_0000_0000_007F, '0);
        send_fields(OP_LOOKUP, 64'h22, 4'd1, 64'h0000_0000_0000_007F, '0);
        send_fields(OP_LOOKUP, 64'h33, 4'd1, 64'h8000_0000_0000_007E, '0);
        send_fields(OP_LOOKUP, 64'h44, 4'd1, 64'h0, '0);
        send_fields(OP_ADD, 64'h1, 4'd0, 64'h1, '0);
        send_fields(OP_ADD, 64'h1, 4'd9, 64'h1, '0);
        send_fields(OP_LOOKUP, 64'h1, 4'd15, 64'h1, '0);
        send_fields(OP_REMOVE, 64'h1, 4'd0, 64'h1, '0);
        send_fields(OP_CLEAR, '0, 4'd0, '0, '0);
        drain();
        set_config(7'd2, 1'b0, 4'd4);
        send_fields(OP_ADD, 64'h1, 4'd1, 64'h10, 64'h1);
        send_fields(OP_ADD, 64'h2, 4'd2, 64'h10, 64'h2);
        send_fields(OP_ADD, 64'h3, 4'd3, 64'h11, 64'h3);
        send_fields(OP_ADD, 64'h4, 4'd5, 64'h12, 64'h4);
        drain();
        set_config(7'd2, 1'b1, 4'd0);
        send_fields(OP_ADD, 64'h1, 4'd1, 64'h10, 64'h1);
        drain();
        set_config(7'd127, 1'b1, 4'd4);
        send_fields(OP_ADD, 64'h3, 4'd3, 64'h11, 64'h3);

        // Random segments under changing settings and idle patterns.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            set_config(seg_limit[seg], seg_evict[seg], seg_longest[seg]);
            if (seg < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 67;
            end else if (seg < 4) begin
                tx_idle_pct = 67;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg == 4) hold_cycles = 600;
            cap = (seg_limit[seg] < 1) ? 1 : ((seg_limit[seg] > 64) ? 64 : seg_limit[seg]);
            fill_pool((cap + 8 > 72) ? 72 : ((cap + 8 < 6) ? 6 : cap + 8));
            for (int n = 0; n < SEG_ITEMS; n++) send_random();
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Run covered %0d requests and %0d checked results, %0d evictions.",
                 sent, sb.checked, sb.evictions);
        $display("Hits %0d, stale %0d, full %0d, removals %0d, errors %0d.",
                 sb.status_seen[RS_HIT], sb.status_seen[RS_STALE], sb.status_seen[RS_FULL],
                 sb.status_seen[RS_REMOVED], sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** lru_hash_cache_engine: PASSED **");
        end else begin
            $display("** lru_hash_cache_engine: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire
